### hdl/utf8_bmp_stream_decoder_unit_assert.svh
// ----------------------------------------------------------------------------
// UTF-8 BMP decoder assertion macros
// Shared assertion wrappers. They compile to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef UTF8_BMP_STREAM_DECODER_UNIT_ASSERT_SVH
`define UTF8_BMP_STREAM_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked check, disabled while reset is held
`define U8D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked check that also holds through reset
`define U8D_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`else

`define U8D_ASSERT(lbl, prop, msg)
`define U8D_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### hdl/u8d_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 BMP decoder package
// Shared types, byte-class masks and status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8d_pkg;

  // Default width of the clean byte counter
  localparam int unsigned DefCountWidth = 16;

  // Field widths
  localparam int unsigned ByteW     = 8;
  localparam int unsigned UnitW     = 16;
  localparam int unsigned ConsumedW = 16;
  localparam int unsigned PartialW  = 10;
  localparam int unsigned ContBitsW = 6;

  // Byte class masks and patterns
  localparam logic [ByteW-1:0] ASCII_MASK  = 8'h80;
  localparam logic [ByteW-1:0] LEAD2_MASK  = 8'hE0;
  localparam logic [ByteW-1:0] LEAD2_PAT   = 8'hC0;
  localparam logic [ByteW-1:0] LEAD3_MASK  = 8'hF0;
  localparam logic [ByteW-1:0] LEAD3_PAT   = 8'hE0;
  localparam logic [ByteW-1:0] CONT_MASK   = 8'hC0;
  localparam logic [ByteW-1:0] CONT_PAT    = 8'h80;
  localparam logic [ByteW-1:0] LEAD2_BITS  = 8'h1F;
  localparam logic [ByteW-1:0] LEAD3_BITS  = 8'h0F;

  // Sequence lengths
  localparam logic [1:0] SEQ_LEN_ONE   = 2'd1;
  localparam logic [1:0] SEQ_LEN_TWO   = 2'd2;
  localparam logic [1:0] SEQ_LEN_THREE = 2'd3;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_TRUNC = 2'd2
  } status_e;

  // One input request held in the input register
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data_byte;
    logic             buffer_end;
  } byte_req_t;

  // One result request
  typedef struct packed {
    logic [UnitW-1:0]     code_unit;
    logic                 unit_valid;
    status_e              status;
    logic                 buffer_done;
    logic [ConsumedW-1:0] consumed;
  } result_t;

endpackage

### hdl/u8d_in_stage.sv
// ----------------------------------------------------------------------------
// UTF-8 BMP decoder input stage
// Registers one incoming byte request and releases it when the decoder pops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8d_in_stage
  import u8d_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [ByteW-1:0] s_axis_tdata,   // [7:0] data_byte
  input  logic             s_axis_tlast,   // buffer_end
  input  logic             pop_i,
  output byte_req_t        req_o
);

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;
  logic             last_q;
  logic             accept;

  // Take a new request when empty or when the held one leaves
  assign s_axis_tready = !valid_q || pop_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
  end

  assign req_o = '{valid: valid_q, data_byte: byte_q, buffer_end: last_q};

endmodule

### hdl/u8d_decode.sv
// ----------------------------------------------------------------------------
// UTF-8 BMP decoder core
// Holds the sequence state; decodes one byte per cycle unless its result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "utf8_bmp_stream_decoder_unit_assert.svh"

module u8d_decode
  import u8d_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = DefCountWidth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  byte_req_t req_i,
  input  logic      out_free_i,
  output logic      pop_o,
  output logic      push_o,
  output result_t   res_o
);

  logic [1:0]             pend_q, pend_d;
  logic [PartialW-1:0]    partial_q, partial_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [1:0]             seqlen_q, seqlen_d;
  logic                   stopped_q, stopped_d;

  logic                   res_vld;
  result_t                res_base;
  logic                   do_add;
  logic [1:0]             add_len;
  logic                   clear;
  logic [ByteW-1:0]       b;
  logic                   last;
  logic [UnitW-1:0]       v;
  logic [COUNT_WIDTH:0]   sum;
  logic [COUNT_WIDTH-1:0] cnt_add;
  logic [ConsumedW-1:0]   cnt_sat;

  assign b    = req_i.data_byte;
  assign last = req_i.buffer_end;
  assign v    = {partial_q, b[ContBitsW-1:0]};

  // Decode the byte against the open sequence
  always_comb begin
    res_vld   = 1'b0;
    res_base  = '0;
    do_add    = 1'b0;
    add_len   = '0;
    clear     = 1'b0;
    pend_d    = pend_q;
    partial_d = partial_q;
    seqlen_d  = seqlen_q;
    stopped_d = stopped_q;
    if (stopped_q) begin
      // drop bytes until the buffer ends
      if (last) begin
        res_vld              = 1'b1;
        res_base.buffer_done = 1'b1;
        clear                = 1'b1;
      end
    end else if (pend_q == 2'd0) begin
      if ((b & ASCII_MASK) == '0) begin
        do_add               = 1'b1;
        add_len              = SEQ_LEN_ONE;
        res_vld              = 1'b1;
        res_base.unit_valid  = 1'b1;
        res_base.code_unit   = {{(UnitW-ByteW){1'b0}}, b};
        res_base.buffer_done = last;
        clear                = last;
      end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
        partial_d = PartialW'(b & LEAD2_BITS);
        pend_d    = 2'd1;
        seqlen_d  = SEQ_LEN_TWO;
        if (last) begin
          res_vld              = 1'b1;
          res_base.status      = ST_TRUNC;
          res_base.buffer_done = 1'b1;
          clear                = 1'b1;
        end
      end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
        partial_d = PartialW'(b & LEAD3_BITS);
        pend_d    = 2'd2;
        seqlen_d  = SEQ_LEN_THREE;
        if (last) begin
          res_vld              = 1'b1;
          res_base.status      = ST_TRUNC;
          res_base.buffer_done = 1'b1;
          clear                = 1'b1;
        end
      end else begin
        // bad lead byte
        res_vld              = 1'b1;
        res_base.status      = ST_BAD;
        res_base.buffer_done = last;
        clear                = last;
        stopped_d            = !last;
      end
    end else if ((b & CONT_MASK) != CONT_PAT) begin
      // bad continuation byte, drop the open sequence
      res_vld              = 1'b1;
      res_base.status      = ST_BAD;
      res_base.buffer_done = last;
      clear                = last;
      stopped_d            = !last;
      pend_d               = '0;
    end else if (pend_q == 2'd1) begin
      // sequence complete
      do_add               = 1'b1;
      add_len              = seqlen_q;
      pend_d               = 2'd0;
      partial_d            = '0;
      seqlen_d             = '0;
      res_vld              = 1'b1;
      res_base.unit_valid  = 1'b1;
      res_base.code_unit   = v;
      res_base.buffer_done = last;
      clear                = last;
    end else begin
      // gather payload bits
      pend_d    = pend_q - 2'd1;
      partial_d = v[PartialW-1:0];
      if (last) begin
        res_vld              = 1'b1;
        res_base.status      = ST_TRUNC;
        res_base.buffer_done = 1'b1;
        clear                = 1'b1;
      end
    end
    if (clear) begin
      pend_d    = '0;
      partial_d = '0;
      seqlen_d  = '0;
      stopped_d = 1'b0;
    end
  end

  // Saturating clean count
  assign sum     = {1'b0, cnt_q} + (COUNT_WIDTH+1)'(add_len);
  assign cnt_add = !do_add          ? cnt_q :
                   sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
  assign cnt_d   = clear ? '0 : cnt_add;

  // Clamp the count to the reported width
  if (COUNT_WIDTH > ConsumedW) begin : g_wide
    assign cnt_sat = (|cnt_add[COUNT_WIDTH-1:ConsumedW]) ? {ConsumedW{1'b1}} :
                     cnt_add[ConsumedW-1:0];
  end else begin : g_narrow
    assign cnt_sat = ConsumedW'(cnt_add);
  end

  always_comb begin
    res_o          = res_base;
    res_o.consumed = cnt_sat;
  end

  // Advance when the request makes no result or the result slot is free
  assign pop_o  = req_i.valid && (!res_vld || out_free_i);
  assign push_o = req_i.valid && res_vld && out_free_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= '0;
      partial_q <= '0;
      cnt_q     <= '0;
      seqlen_q  <= '0;
      stopped_q <= 1'b0;
    end else if (pop_o) begin
      pend_q    <= pend_d;
      partial_q <= partial_d;
      cnt_q     <= cnt_d;
      seqlen_q  <= seqlen_d;
      stopped_q <= stopped_d;
    end
  end

  `U8D_ASSERT_ALWAYS(a_stop_no_pend, stopped_q |-> pend_q == 2'd0, "stopped with open sequence")
  `U8D_ASSERT(a_pend_len,
    (pend_q != 2'd0) |-> (seqlen_q >= SEQ_LEN_TWO && pend_q < seqlen_q),
    "pending count exceeds sequence")
  `U8D_ASSERT(a_end_clears,
    (pop_o && req_i.buffer_end) |=> (pend_q == 2'd0 && !stopped_q && cnt_q == '0),
    "state not cleared at buffer end")
  `U8D_ASSERT(a_cnt_grows, (pop_o && !req_i.buffer_end) |=> cnt_q >= $past(cnt_q),
    "clean count fell inside a buffer")
  `U8D_ASSERT(a_unit_ok, (push_o && res_o.unit_valid) |-> res_o.status == ST_OK,
    "unit with error status")

endmodule

### hdl/u8d_out_stage.sv
// ----------------------------------------------------------------------------
// UTF-8 BMP decoder output stage
// Registers one result request and presents it on the master stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8d_out_stage
  import u8d_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  result_t                       res_i,
  output logic                          free_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [UnitW+ConsumedW-1:0]    m_axis_tdata,  // [15:0] code_unit, [31:16] consumed
  output logic [2:0]                    m_axis_tuser,  // [0] unit_valid, [2:1] status
  output logic                          m_axis_tlast   // buffer_done
);

  logic    valid_q, valid_d;
  result_t res_q;

  // Slot can take a result when empty or being drained
  assign free_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {res_q.consumed, res_q.code_unit};
  assign m_axis_tuser  = {res_q.status, res_q.unit_valid};
  assign m_axis_tlast  = res_q.buffer_done;

endmodule

### hdl/utf8_bmp_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// UTF-8 BMP stream decoder
// Decodes one- to three-byte UTF-8 sequences into 16-bit code units.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one raw byte per request in tdata[7:0]; tlast
//   marks the last byte of a buffer. The master stream carries at most one
//   result per byte: tdata[15:0] code unit, tdata[31:16] clean byte count,
//   tuser[0] unit valid, tuser[2:1] status (0 ok, 1 bad byte, 2 truncated),
//   tlast marks the last result of a buffer.
//   A byte that completes a character, hits a bad byte, or ends a buffer
//   gives one result; lead bytes and middle continuation bytes give none.
//   After a bad byte the rest of the buffer is dropped and its last byte
//   gives a closing result with the clean count.
//   Throughput is one byte per cycle unless a result waits on a full result
//   register. A byte is held in the input register while the decode logic
//   loads its result, if any, into the result register, which then drives
//   the master stream. When the receiver stalls, the result register holds;
//   bytes that give no result still pass, and the input register takes one
//   more byte before tready drops. Reset clears all sequence state and the
//   valid flags of both registers, and the block is ready once reset is
//   released.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_bmp_stream_decoder_unit
  import u8d_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = DefCountWidth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [ByteW-1:0]           s_axis_tdata,   // [7:0] data_byte
  input  logic                       s_axis_tlast,   // buffer_end
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [UnitW+ConsumedW-1:0] m_axis_tdata,   // [15:0] code_unit, [31:16] consumed
  output logic [2:0]                 m_axis_tuser,   // [0] unit_valid, [2:1] status
  output logic                       m_axis_tlast    // buffer_done
);

  byte_req_t req;
  result_t   res;
  logic      pop;
  logic      push;
  logic      out_free;

  // Input register
  u8d_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .pop_i         (pop),
    .req_o         (req)
  );

  // Decode logic and sequence state
  u8d_decode #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .out_free_i (out_free),
    .pop_o      (pop),
    .push_o     (push),
    .res_o      (res)
  );

  // Result register
  u8d_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .res_i         (res),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
